@@ rtl/ntc_pkg.sv @@
// shared types, constants and register map for the thermistor converter
package ntc_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int CNT_W       = 7;
   localparam int SUM_W       = 21;

   localparam logic [29:0] LN2_Q30       = 30'd744261118;
   localparam logic [16:0] KELVIN_OFFSET = 17'd27315;
   localparam logic [61:0] TCK_MAX       = 62'd60082;

   localparam logic signed [15:0] TEMP_HIGH = 16'sd32767;
   localparam logic signed [15:0] TEMP_LOW  = -16'sd27315;
   localparam logic signed [15:0] TEMP_ZERO = 16'sd0;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_RAIL = 2'd2;

   localparam logic [2:0] REG_SERIES = 3'd0;
   localparam logic [2:0] REG_NOMR   = 3'd1;
   localparam logic [2:0] REG_BETA   = 3'd2;
   localparam logic [2:0] REG_NOMT   = 3'd3;
   localparam logic [2:0] REG_FS     = 3'd4;

   typedef struct packed {
      logic [19:0] rs;
      logic [19:0] r0;
      logic [13:0] beta;
      logic [15:0] t0;
      logic [14:0] fs;
   } ntc_cfg_type;

endpackage

@@ rtl/ntc_mul.sv @@
// shared 32x32 multiplier with registered product
module ntc_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;
endmodule

@@ rtl/ntc_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module ntc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] dividend,
   input  logic [46:0] divisor,
   output logic        done,
   output logic [61:0] quotient
);
   logic [61:0] q_ff;
   logic [46:0] rem_ff;
   logic [46:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [47:0] rem_sh;
   logic        ge;

   assign rem_sh = {rem_ff, q_ff[61]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            q_ff   <= dividend;
            rem_ff <= '0;
            dvs_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= ge ? 47'(rem_sh - {1'b0, dvs_ff}) : rem_sh[46:0];
            q_ff   <= {q_ff[60:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd61) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

@@ rtl/ntc_csr.sv @@
// configuration registers behind the apb port
module ntc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output ntc_pkg::ntc_cfg_type cfg
);
   import ntc_pkg::*;

   ntc_cfg_type cfg_ff;
   logic        wr;

   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rs   <= 20'd10000;
         cfg_ff.r0   <= 20'd10000;
         cfg_ff.beta <= 14'd3950;
         cfg_ff.t0   <= 16'd29815;
         cfg_ff.fs   <= 15'd4095;
      end else if (wr) begin
         unique case (paddr[4:2])
            REG_SERIES: cfg_ff.rs   <= pwdata[19:0];
            REG_NOMR:   cfg_ff.r0   <= pwdata[19:0];
            REG_BETA:   cfg_ff.beta <= pwdata[13:0];
            REG_NOMT:   cfg_ff.t0   <= pwdata[15:0];
            REG_FS:     cfg_ff.fs   <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_SERIES: prdata = {12'd0, cfg_ff.rs};
         REG_NOMR:   prdata = {12'd0, cfg_ff.r0};
         REG_BETA:   prdata = {18'd0, cfg_ff.beta};
         REG_NOMT:   prdata = {16'd0, cfg_ff.t0};
         REG_FS:     prdata = {17'd0, cfg_ff.fs};
         default:    prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

@@ rtl/thermistor_average_to_temperature.sv @@
// burst averager and beta-equation temperature converter, top level
//
// channel   ports                                   handshake
// input     req_raw_sample, req_last_sample         start & !busy
// result    rsp_temperature_centi_c, rsp_status,    rsp_valid, one cycle
//           rsp_valid_count
// config    psel penable pwrite paddr pwdata prdata write at access cycle
//
// a sample without the last flag stays in idle; the next beat follows at once
// a last sample runs the conversion on the shared multiplier and the serial
// divider: two leading-one searches, 2 x 24 squarings, twelve control and
// multiply steps and a divide wait
// synchronous reset clears the accumulator and sequencer, no clearing pass
// results are strobed for one cycle and cannot be held off
module thermistor_average_to_temperature (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_raw_sample,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_temperature_centi_c,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_valid_count,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ntc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_SPAN, S_NUM, S_DEN, S_NORM, S_SQ, S_SQW, S_LNM, S_LNW,
      S_XT, S_XTW, S_B1W, S_B2, S_B2W, S_DENOM, S_DIVW
   } state_type;

   ntc_cfg_type cfg;
   state_type   state_ff;

   logic [SUM_W-1:0] sum_ff, sum_in, bsum_ff;
   logic [CNT_W-1:0] tally_ff, tally_in, n_ff;
   logic             acc_ok;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic [21:0] dv_ff;
   logic [41:0] num_ff, den_ff;
   logic [47:0] norm_ff;
   logic [5:0]  sh_ff, k_ff;
   logic [30:0] m_ff;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  it_ff;
   logic        lsel_ff;
   logic [29:0] lg0_ff, lg_new;
   logic [30:0] diff;
   logic        neg_ff;
   logic [29:0] mag_ff, mag2_ff;
   logic [45:0] xt_ff;
   logic [20:0] b100_ff;
   logic [36:0] bt_ff;
   logic [31:0] sq_t;
   logic [47:0] denom, bshift;
   logic [60:0] lnp;

   logic        div_start;
   logic [61:0] div_dividend, div_q;
   logic        div_done;
   logic [16:0] tc;

   logic               rv_ff;
   logic signed [15:0] rt_ff;
   logic [1:0]         rs_ff;
   logic [6:0]         rc_ff;

   ntc_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   ntc_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   ntc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(denom[46:0]), .done(div_done), .quotient(div_q)
   );

   assign busy   = state_ff != S_IDLE;
   assign acc_ok = !req_raw_sample[15] && (req_raw_sample[14:0] <= cfg.fs)
                   && (tally_ff < CNT_W'(MAX_SAMPLES));
   assign sum_in   = acc_ok ? sum_ff + SUM_W'(req_raw_sample[14:0]) : sum_ff;
   assign tally_in = acc_ok ? tally_ff + CNT_W'(1) : tally_ff;

   assign sq_t    = mul_p[61:30];
   assign frac_in = {frac_ff[22:0], sq_t[31]};
   assign lg_new  = {k_ff, frac_in};
   assign diff    = {1'b0, lg0_ff} - {1'b0, lg_new};
   assign lnp     = mul_p[60:0] + 61'(1 << 29);
   assign bshift  = {3'd0, b100_ff, 24'd0};
   assign denom   = neg_ff ? bshift - {2'd0, xt_ff} : bshift + {2'd0, xt_ff};
   assign div_dividend = {1'b0, bt_ff, 24'd0} + {15'd0, denom[47:1]};
   assign div_start    = (state_ff == S_DENOM) && !denom[47] && (denom != 48'd0);
   assign tc           = {1'b0, div_q[15:0]} - KELVIN_OFFSET;

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_CHK:  begin mul_a = 32'(cfg.fs);   mul_b = 32'(n_ff);    end
         S_SPAN: begin mul_a = 32'(cfg.rs);   mul_b = 32'(bsum_ff); end
         S_NUM:  begin mul_a = 32'(cfg.r0);   mul_b = 32'(dv_ff);   end
         S_SQ:   begin mul_a = 32'(m_ff);     mul_b = 32'(m_ff);    end
         S_LNM:  begin mul_a = 32'(mag_ff);   mul_b = 32'(LN2_Q30); end
         S_XT:   begin mul_a = 32'(mag2_ff);  mul_b = 32'(cfg.t0);  end
         S_XTW:  begin mul_a = 32'(cfg.beta); mul_b = 32'd100;      end
         S_B2:   begin mul_a = 32'(b100_ff);  mul_b = 32'(cfg.t0);  end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff   <= '0;
         tally_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_last_sample) begin
                     bsum_ff  <= sum_in;
                     n_ff     <= tally_in;
                     sum_ff   <= '0;
                     tally_ff <= '0;
                     state_ff <= S_CHK;
                  end else begin
                     sum_ff   <= sum_in;
                     tally_ff <= tally_in;
                  end
               end
            end
            S_CHK: begin
               rc_ff <= n_ff;
               if (n_ff == '0) begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_ZERO; rs_ff <= STAT_NONE;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_SPAN;
               end
            end
            S_SPAN: begin
               dv_ff <= mul_p[21:0] - 22'(bsum_ff);
               if (bsum_ff == '0) begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_HIGH; rs_ff <= STAT_RAIL;
                  state_ff <= S_IDLE;
               end else if (22'(bsum_ff) >= mul_p[21:0]) begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_LOW; rs_ff <= STAT_RAIL;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_NUM;
               end
            end
            S_NUM: begin
               num_ff   <= mul_p[41:0];
               state_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff  <= mul_p[41:0];
               norm_ff <= {6'd0, num_ff};
               sh_ff   <= '0;
               lsel_ff <= 1'b0;
               rs_ff   <= STAT_OK;
               if (num_ff == '0) begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_HIGH;
                  state_ff <= S_IDLE;
               end else if (mul_p[41:0] == '0) begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_LOW;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (norm_ff[47]) begin
                  m_ff     <= norm_ff[47:17];
                  k_ff     <= 6'd47 - sh_ff;
                  frac_ff  <= '0;
                  it_ff    <= '0;
                  state_ff <= S_SQ;
               end else begin
                  norm_ff <= {norm_ff[46:0], 1'b0};
                  sh_ff   <= sh_ff + 6'd1;
               end
            end
            S_SQ: state_ff <= S_SQW;
            S_SQW: begin
               m_ff    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
               frac_ff <= frac_in;
               it_ff   <= it_ff + 5'd1;
               if (it_ff == 5'd23) begin
                  if (!lsel_ff) begin
                     lg0_ff   <= lg_new;
                     norm_ff  <= {6'd0, den_ff};
                     sh_ff    <= '0;
                     lsel_ff  <= 1'b1;
                     state_ff <= S_NORM;
                  end else begin
                     neg_ff   <= diff[30];
                     mag_ff   <= diff[30] ? 30'(-diff) : diff[29:0];
                     state_ff <= S_LNM;
                  end
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_LNM: state_ff <= S_LNW;
            S_LNW: begin
               mag2_ff  <= lnp[59:30];
               state_ff <= S_XT;
            end
            S_XT:  state_ff <= S_XTW;
            S_XTW: begin
               xt_ff    <= mul_p[45:0];
               state_ff <= S_B1W;
            end
            S_B1W: begin
               b100_ff  <= mul_p[20:0];
               state_ff <= S_B2;
            end
            S_B2:  state_ff <= S_B2W;
            S_B2W: begin
               bt_ff    <= mul_p[36:0];
               state_ff <= S_DENOM;
            end
            S_DENOM: begin
               if (div_start) begin
                  state_ff <= S_DIVW;
               end else begin
                  rv_ff <= 1'b1; rt_ff <= TEMP_HIGH;
                  state_ff <= S_IDLE;
               end
            end
            S_DIVW: begin
               if (div_done) begin
                  rv_ff    <= 1'b1;
                  rt_ff    <= (div_q > TCK_MAX) ? TEMP_HIGH : signed'(tc[15:0]);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid               = rv_ff;
   assign rsp_temperature_centi_c = rt_ff;
   assign rsp_status              = rs_ff;
   assign rsp_valid_count         = rc_ff;

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_mid_burst: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_sample |=> !busy && !rsp_valid)
      else $error("non-last beat started a conversion");
   a_none_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NONE) |-> rsp_valid_count == 7'd0)
      else $error("empty burst with nonzero count");
   a_tally_cap: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= CNT_W'(MAX_SAMPLES)) else $error("sample tally beyond limit");
`endif
endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the thermistor burst averager and temperature converter
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ntc_pkg::*;

   typedef struct {
      logic signed [15:0] raw;
      logic               last;
   } sample_beat_type;

   typedef struct {
      logic signed [15:0] temp;
      logic [1:0]         stat;
      logic [6:0]         count;
   } reading_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_raw_sample = '0;
   logic               req_last_sample = 1'b0;
   logic               rsp_valid;
   logic signed [15:0] rsp_temperature_centi_c;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_valid_count;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   thermistor_average_to_temperature u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sample_beat_type sample_q[$];
   reading_type     pending_readings[$];
   int              errors = 0;
   longint          cycles = 0;
   logic            accepted = 1'b0;
   int              gap_left = 0;
   bit              no_gaps = 1'b0;

   // predictor copy of configuration and accumulator
   logic [19:0] cfg_rs = 20'd10000;
   logic [19:0] cfg_r0 = 20'd10000;
   logic [13:0] cfg_beta = 14'd3950;
   logic [15:0] cfg_t0 = 16'd29815;
   logic [14:0] cfg_fs = 15'd4095;
   logic [20:0] acc_sum = '0;
   logic [6:0]  acc_count = '0;

   function automatic longint log2_q24(longint unsigned v);
      int k;
      longint unsigned m;
      longint frac;
      k = 63;
      frac = 0;
      while (k > 0 && v[k] == 1'b0) k--;
      if (k >= 30) m = v >> (k - 30);
      else m = v << (30 - k);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(k) * (longint'(1) << 24) + frac;
   endfunction

   function automatic reading_type predict_temperature(longint unsigned sum,
                                                       longint unsigned n);
      reading_type r;
      longint unsigned span, num, den, mag, numer, tck;
      longint diff, x, denom;
      r.count = n[6:0];
      r.stat = STAT_OK;
      span = longint'(cfg_fs) * n;
      if (n == 0) begin
         r.stat = STAT_NONE;
         r.temp = TEMP_ZERO;
         return r;
      end
      if (sum == 0) begin
         r.stat = STAT_RAIL;
         r.temp = TEMP_HIGH;
         return r;
      end
      if (sum >= span) begin
         r.stat = STAT_RAIL;
         r.temp = TEMP_LOW;
         return r;
      end
      num = longint'(cfg_rs) * sum;
      den = longint'(cfg_r0) * (span - sum);
      if (num == 0) begin
         r.temp = TEMP_HIGH;
         return r;
      end
      if (den == 0) begin
         r.temp = TEMP_LOW;
         return r;
      end
      diff = log2_q24(num) - log2_q24(den);
      mag = (diff < 0) ? -diff : diff;
      mag = (mag * longint'(LN2_Q30) + (64'd1 << 29)) >> 30;
      x = (diff < 0) ? -longint'(mag) : longint'(mag);
      numer = 64'd100 * cfg_beta * cfg_t0 * (64'd1 << 24);
      denom = x * longint'(cfg_t0) + longint'(64'd100 * cfg_beta * (64'd1 << 24));
      if (denom <= 0) begin
         r.temp = TEMP_HIGH;
         return r;
      end
      tck = (numer + longint'(denom) / 2) / longint'(denom);
      if (tck > 64'd32767 + KELVIN_OFFSET) r.temp = TEMP_HIGH;
      else r.temp = 16'(longint'(tck) - longint'(KELVIN_OFFSET));
      return r;
   endfunction

   // input beats: prediction on acceptance
   always @(posedge clock) begin
      logic signed [15:0] s;
      cycles <= cycles + 1;
      accepted <= 1'b0;
      if (!reset && start && !busy) begin
         accepted <= 1'b1;
         s = req_raw_sample;
         if (s >= 0 && s <= $signed({1'b0, cfg_fs}) && acc_count < MAX_SAMPLES) begin
            acc_sum = acc_sum + 21'(s);
            acc_count = acc_count + 1;
         end
         if (req_last_sample) begin
            pending_readings.push_back(predict_temperature(acc_sum, acc_count));
            acc_sum = '0;
            acc_count = '0;
         end
      end
   end

   // result beats
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result temp %0d status %0d count %0d", $time,
                     rsp_temperature_centi_c, rsp_status, rsp_valid_count);
            errors++;
         end else begin
            e = pending_readings.pop_front();
            if (rsp_temperature_centi_c !== e.temp) begin
               $display("%0t: temperature expected %0d actual %0d", $time, e.temp,
                        rsp_temperature_centi_c);
               errors++;
            end
            if (rsp_status !== e.stat) begin
               $display("%0t: status expected %0d actual %0d", $time, e.stat, rsp_status);
               errors++;
            end
            if (rsp_valid_count !== e.count) begin
               $display("%0t: valid_count expected %0d actual %0d", $time, e.count,
                        rsp_valid_count);
               errors++;
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      sample_beat_type b;
      if (!reset && (!start || accepted)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (sample_q.size() > 0) begin
            b = sample_q.pop_front();
            start <= 1'b1;
            req_raw_sample <= b.raw;
            req_last_sample <= b.last;
            if ($urandom_range(0, 99) < 3) no_gaps <= ~no_gaps;
            if (no_gaps || $urandom_range(0, 99) < 60) gap_left <= 0;
            else if ($urandom_range(0, 99) < 90) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 60);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 4000000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_beat(logic signed [15:0] raw, logic last);
      sample_beat_type b;
      b.raw = raw;
      b.last = last;
      sample_q.push_back(b);
   endtask

   // kind: 0 in range, 1 zeros, 2 full scale, 3 any code, 4 mostly in range
   task automatic push_burst(int len, int kind);
      logic signed [15:0] v;
      for (int i = 0; i < len; i++) begin
         case (kind)
            1: v = 16'sd0;
            2: v = $signed({1'b0, cfg_fs});
            3: v = $signed(16'($urandom));
            default: v = $signed(16'($urandom_range(0, cfg_fs)));
         endcase
         if (kind == 4 && $urandom_range(0, 9) == 0) v = $signed(16'($urandom));
         push_beat(v, i == len - 1);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SERIES: cfg_rs = value[19:0];
         REG_NOMR:   cfg_r0 = value[19:0];
         REG_BETA:   cfg_beta = value[13:0];
         REG_NOMT:   cfg_t0 = value[15:0];
         default:    cfg_fs = value[14:0];
      endcase
   endtask

   task automatic wait_drained();
      while (sample_q.size() > 0 || start || pending_readings.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_phase(int items);
      int sent;
      int len;
      int r;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(0, 99);
         if (r < 5) len = $urandom_range(65, 72);
         else if (r < 50) len = $urandom_range(1, 4);
         else len = $urandom_range(1, 20);
         if (r < 70) push_burst(len, 0);
         else if (r < 88) push_burst(len, 4);
         else if (r < 94) push_burst(len, 3);
         else push_burst(len, $urandom_range(1, 2));
         sent += len;
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_beat(-16'sd1, 1'b1);
      push_beat(16'sd2048, 1'b1);
      push_beat(16'sd0, 1'b0);
      push_beat(16'sd0, 1'b1);
      push_beat(16'sd4095, 1'b0);
      push_beat(16'sd4095, 1'b1);
      push_beat(-16'sd32768, 1'b0);
      push_beat(16'sd32767, 1'b0);
      push_beat(16'sd4096, 1'b1);
      push_beat(16'sd1, 1'b0);
      push_beat(16'sd4094, 1'b1);
      push_beat(16'sd1, 1'b1);
      push_beat(16'sd4094, 1'b1);
      push_beat(16'sd100, 1'b0);
      push_beat(-16'sd5, 1'b0);
      push_beat(16'sd3000, 1'b1);
      wait_drained();

      write_reg(REG_SERIES, 32'd1);
      write_reg(REG_NOMR, 32'd1000000);
      write_reg(REG_BETA, 32'd1);
      write_reg(REG_NOMT, 32'd1);
      write_reg(REG_FS, 32'd32767);
      push_beat(16'sd32767, 1'b0);
      push_beat(16'sd1, 1'b1);
      push_beat(16'sd16000, 1'b1);
      random_phase(200);

      write_reg(REG_SERIES, 32'd1000000);
      write_reg(REG_NOMR, 32'd1);
      write_reg(REG_BETA, 32'd10000);
      write_reg(REG_NOMT, 32'd65535);
      write_reg(REG_FS, 32'd1);
      random_phase(200);

      write_reg(REG_FS, 32'd4095);
      random_phase(200);

      write_reg(REG_SERIES, 32'd10000);
      write_reg(REG_NOMR, 32'd10000);
      write_reg(REG_BETA, 32'd3950);
      write_reg(REG_NOMT, 32'd29815);
      random_phase(350);

      for (int p = 0; p < 5; p++) begin
         write_reg(REG_SERIES, $urandom_range(1, 1000000));
         write_reg(REG_NOMR, $urandom_range(1, 1000000));
         write_reg(REG_BETA, $urandom_range(1, 10000));
         write_reg(REG_NOMT, $urandom_range(1, 65535));
         write_reg(REG_FS, (p == 0) ? 32'd1023 : $urandom_range(1, 32767));
         random_phase(190);
      end

      wait_drained();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ thermistor_average_to_temperature.f @@
rtl/ntc_pkg.sv
rtl/ntc_mul.sv
rtl/ntc_div.sv
rtl/ntc_csr.sv
rtl/thermistor_average_to_temperature.sv
tb/tb_top.sv
